>>> src/ale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  // List geometry
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 2'd0,
    MODE_MIN     = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_REMOVE  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_FIX,
    ST_RV_RD_I,
    ST_RV_RD_J,
    ST_RV_WR_I,
    ST_RV_WR_J,
    ST_DONE
  } state_t;

endpackage

>>> src/ale_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_if
// Request and result channels of the array list engine.
// ----------------------------------------------------------------------------

// Request channel: one beat per list operation
interface ale_in_if;
  logic                              valid;
  logic                              ready;
  logic [ale_pkg::MODE_W-1:0]        mode;
  logic signed [ale_pkg::WORD_W-1:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

// Result channel: one beat per request
interface ale_out_if;
  logic                              valid;
  logic                              ready;
  logic [ale_pkg::STAT_W-1:0]        status;
  logic signed [ale_pkg::WORD_W-1:0] min_value;
  logic [ale_pkg::CNT_W-1:0]         count_after;

  modport source (output valid, output status, output min_value, output count_after,
                  input ready);
  modport sink   (input valid, input status, input min_value, input count_after,
                  output ready);
endinterface

>>> src/array_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Fixed-capacity list of signed words: append, extract-min, reverse and
// remove-key, run by a small sequencer over a one-read one-write word RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time; the request port is ready only while the
// sequencer is idle, and a finished result waits in the output register while
// the next request is taken. All work goes through the single word RAM port
// pair (registered read): append writes one word, extract-min scans all words
// and then moves the last word into the freed slot, remove-key scans and
// compacts, reverse reads and writes each pair in turn, and a request on an
// empty list (or append on a full one) goes straight to the result. The store
// needs no clearing: only words below the count are ever read.
module array_list_engine_unit (
  input  logic     clk,
  input  logic     rst_n,
  ale_in_if.sink   in_ch,
  ale_out_if.source out_ch
);

  localparam int AW = ale_pkg::ADDR_W;
  localparam int CW = ale_pkg::CNT_W;
  localparam int WW = ale_pkg::WORD_W;

  ale_pkg::state_t  state_r, state_nxt;
  ale_pkg::mode_t   mode_r, mode_nxt;
  ale_pkg::status_t status_r, status_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]        kept_r, kept_nxt;
  logic                 dv_r, dv_nxt;
  logic [AW-1:0]        dv_idx_r, dv_idx_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        rv_i_r, rv_i_nxt;
  logic signed [WW-1:0] key_r, key_nxt;
  logic signed [WW-1:0] min_r, min_nxt;
  logic signed [WW-1:0] last_r, last_nxt;
  logic signed [WW-1:0] tmp_r, tmp_nxt;

  // Word RAM
  logic signed [WW-1:0] mem [ale_pkg::CAPACITY];
  logic signed [WW-1:0] rd_data_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic signed [WW-1:0] mem_wd;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic signed [WW-1:0] out_min_r, out_min_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;

  logic          in_fire;
  logic          out_load;
  logic          issue;
  logic          scan_end;
  logic [CW-1:0] half_cnt;
  logic [CW-1:0] rv_j;
  logic [CW-1:0] rv_i_inc;

  assign in_ch.ready        = (state_r == ale_pkg::ST_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_load           = (state_r == ale_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign issue              = (rd_idx_r < cnt_r);
  assign scan_end           = !issue && !dv_r;
  assign half_cnt           = cnt_r >> 1;
  assign rv_j               = cnt_r - CW'(1) - CW'(rv_i_r);
  assign rv_i_inc           = CW'(rv_i_r) + CW'(1);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.min_value   = out_min_r;
  assign out_ch.count_after = out_count_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ale_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (ale_pkg::mode_t'(in_ch.mode))
            ale_pkg::MODE_APPEND:
              state_nxt = (cnt_r == CW'(ale_pkg::CAPACITY)) ? ale_pkg::ST_DONE
                                                            : ale_pkg::ST_APPEND;
            ale_pkg::MODE_REVERSE:
              state_nxt = (half_cnt != '0) ? ale_pkg::ST_RV_RD_I : ale_pkg::ST_DONE;
            default:
              state_nxt = (cnt_r != '0) ? ale_pkg::ST_SCAN : ale_pkg::ST_DONE;
          endcase
        end
      end
      ale_pkg::ST_APPEND:  state_nxt = ale_pkg::ST_DONE;
      ale_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (mode_r == ale_pkg::MODE_MIN) ? ale_pkg::ST_FIX : ale_pkg::ST_DONE;
        end
      end
      ale_pkg::ST_FIX:     state_nxt = ale_pkg::ST_DONE;
      ale_pkg::ST_RV_RD_I: state_nxt = ale_pkg::ST_RV_RD_J;
      ale_pkg::ST_RV_RD_J: state_nxt = ale_pkg::ST_RV_WR_I;
      ale_pkg::ST_RV_WR_I: state_nxt = ale_pkg::ST_RV_WR_J;
      ale_pkg::ST_RV_WR_J:
        state_nxt = (rv_i_inc < half_cnt) ? ale_pkg::ST_RV_RD_I : ale_pkg::ST_DONE;
      ale_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = ale_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = ale_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    dv_nxt         = 1'b0;
    dv_idx_nxt     = dv_idx_r;
    pos_nxt        = pos_r;
    rv_i_nxt       = rv_i_r;
    key_nxt        = key_r;
    min_nxt        = min_r;
    last_nxt       = last_r;
    tmp_nxt        = tmp_r;
    mem_we         = 1'b0;
    mem_wa         = cnt_r[AW-1:0];
    mem_wd         = key_r;
    mem_ra         = rd_idx_r[AW-1:0];
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      // Latch the request and pick the early status
      ale_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = ale_pkg::mode_t'(in_ch.mode);
          key_nxt    = in_ch.operand;
          rd_idx_nxt = '0;
          kept_nxt   = '0;
          rv_i_nxt   = '0;
          pos_nxt    = '0;
          min_nxt    = '0;
          status_nxt = ale_pkg::STAT_DONE;
          if (ale_pkg::mode_t'(in_ch.mode) == ale_pkg::MODE_APPEND) begin
            if (cnt_r == CW'(ale_pkg::CAPACITY)) begin
              status_nxt = ale_pkg::STAT_FULL;
            end
          end else if (cnt_r == '0) begin
            status_nxt = ale_pkg::STAT_EMPTY;
          end
        end
      end
      ale_pkg::ST_APPEND: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r[AW-1:0];
        mem_wd  = key_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      // Streaming read of all words; one compare per returned word
      ale_pkg::ST_SCAN: begin
        mem_ra = rd_idx_r[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          dv_nxt     = 1'b1;
          dv_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (dv_r) begin
          if (mode_r == ale_pkg::MODE_MIN) begin
            if ((dv_idx_r == '0) || (rd_data_r < min_r)) begin
              min_nxt = rd_data_r;
              pos_nxt = dv_idx_r;
            end
            if (CW'(dv_idx_r) == cnt_r - CW'(1)) begin
              last_nxt = rd_data_r;
            end
          end else if (rd_data_r != key_r) begin
            mem_we   = 1'b1;
            mem_wa   = kept_r[AW-1:0];
            mem_wd   = rd_data_r;
            kept_nxt = kept_r + CW'(1);
          end
        end
        if (scan_end && (mode_r != ale_pkg::MODE_MIN)) begin
          cnt_nxt = kept_r;
        end
      end
      // Move the last word into the freed slot
      ale_pkg::ST_FIX: begin
        mem_we  = 1'b1;
        mem_wa  = pos_r;
        mem_wd  = last_r;
        cnt_nxt = cnt_r - CW'(1);
      end
      // Reverse: swap one pair through read i, read j, write i, write j
      ale_pkg::ST_RV_RD_I: begin
        mem_ra = rv_i_r;
      end
      ale_pkg::ST_RV_RD_J: begin
        mem_ra  = rv_j[AW-1:0];
        tmp_nxt = rd_data_r;
      end
      ale_pkg::ST_RV_WR_I: begin
        mem_we = 1'b1;
        mem_wa = rv_i_r;
        mem_wd = rd_data_r;
      end
      ale_pkg::ST_RV_WR_J: begin
        mem_we   = 1'b1;
        mem_wa   = rv_j[AW-1:0];
        mem_wd   = tmp_r;
        rv_i_nxt = rv_i_r + AW'(1);
      end
      // Hand the result to the output register
      ale_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_min_nxt    = ((mode_r == ale_pkg::MODE_MIN) && (status_r == ale_pkg::STAT_DONE))
                           ? min_r : '0;
          out_count_nxt  = cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Word RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ale_pkg::ST_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    rd_idx_r     <= rd_idx_nxt;
    kept_r       <= kept_nxt;
    dv_idx_r     <= dv_idx_nxt;
    pos_r        <= pos_nxt;
    rv_i_r       <= rv_i_nxt;
    key_r        <= key_nxt;
    min_r        <= min_nxt;
    last_r       <= last_nxt;
    tmp_r        <= tmp_nxt;
    out_status_r <= out_status_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef SYNTHESIS
  // Count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ale_pkg::CAPACITY))
    else $error("word count above capacity");

  // Compaction write pointer never overtakes the read pointer
  a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ale_pkg::ST_SCAN) |-> (kept_r <= rd_idx_r))
    else $error("compaction pointer ahead of read pointer");

  // Extract-min writes inside the live list
  a_fix_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ale_pkg::ST_FIX) |-> (CW'(pos_r) < cnt_r))
    else $error("minimum slot outside list");

  // Reverse only touches the lower half as its left index
  a_rv_index: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ale_pkg::ST_RV_RD_I) || (state_r == ale_pkg::ST_RV_WR_J))
      |-> (CW'(rv_i_r) < half_cnt))
    else $error("reverse index past midpoint");

  // A loaded result carries the final count
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (out_count_r == $past(cnt_r))))
    else $error("result count mismatch");
`endif

endmodule
